// File: hdl/smpl_pkg.sv
// ----------------------------------------------------------------------------
// Sorted merge priority list package
// Shared types, status and operation codes, and the saturating doubler used
// by the list cells.
// ----------------------------------------------------------------------------
package smpl_pkg;

    localparam int VALUE_W  = 32;
    localparam int KEY_W    = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_INSERTED = 3'd0,
        ST_MERGED   = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // What every cell does in the current cycle.
    typedef enum logic [1:0]
    {
        ACT_HOLD   = 2'd0,
        ACT_MERGE  = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_REMOVE = 2'd3
    } act_t;

    typedef struct packed
    {
        logic signed [VALUE_W-1:0] value;
        logic        [KEY_W-1:0]   key;
    } entry_t;

    // What a cell shows its neighbors.
    typedef struct packed
    {
        logic signed [VALUE_W-1:0] value;
        logic        [KEY_W-1:0]   key;
        logic                      ge;
    } cell_tap_t;

    function automatic logic signed [VALUE_W-1:0] double_sat(
        input logic signed [VALUE_W-1:0] v
    );
        logic signed [VALUE_W-1:0] r;
        begin
            if (v[VALUE_W-1] != v[VALUE_W-2])
            begin
                r = v[VALUE_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                 : {1'b0, {(VALUE_W-1){1'b1}}};
            end
            else
            begin
                r = {v[VALUE_W-2:0], 1'b0};
            end
            return r;
        end
    endfunction

endpackage

// File: hdl/smpl_cell.sv
// ----------------------------------------------------------------------------
// Sorted merge priority list cell
// Holds one entry, compares it against the broadcast command and takes its
// next contents from itself, the command or one of its two neighbors.
// ----------------------------------------------------------------------------
module smpl_cell
    import smpl_pkg::*;
(
    input  logic      clk,
    input  act_t      act,
    input  entry_t    cmd,
    input  logic      occupied,
    input  cell_tap_t tap_left,
    input  cell_tap_t tap_right,
    input  logic      found_in,
    output logic      found_out,
    output cell_tap_t tap,
    output entry_t    nxt
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic        [KEY_W-1:0]   key_reg;
    logic        [KEY_W-1:0]   key_next;
    logic                      match;
    logic                      first;
    logic                      ge;

    assign match     = occupied && (value_reg == cmd.value);
    assign first     = match && !found_in;
    assign found_out = found_in || match;

    // The list is sorted, so ge is false up to the insert position and true
    // from there on; empty cells always count as true.
    assign ge = !occupied || (cmd.key >= key_reg);

    assign tap = '{value: value_reg, key: key_reg, ge: ge};

    always_comb
    begin
        value_next = value_reg;
        key_next   = key_reg;
        case (act)
            ACT_MERGE:
            begin
                if (first)
                begin
                    value_next = double_sat(value_reg);
                end
            end
            ACT_INSERT:
            begin
                if (ge)
                begin
                    if (tap_left.ge)
                    begin
                        value_next = tap_left.value;
                        key_next   = tap_left.key;
                    end
                    else
                    begin
                        value_next = cmd.value;
                        key_next   = cmd.key;
                    end
                end
            end
            ACT_REMOVE:
            begin
                value_next = tap_right.value;
                key_next   = tap_right.key;
            end
            default:
            begin
                value_next = value_reg;
                key_next   = key_reg;
            end
        endcase
    end

    assign nxt = '{value: value_next, key: key_next};

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        key_reg   <= key_next;
    end

endmodule

// File: hdl/sorted_merge_priority_list_core.sv
// ----------------------------------------------------------------------------
// Sorted merge priority list core
// Bounded list of (value, key) entries in descending key order, built as a
// row of cells, with merge-by-doubling on equal values.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries one command per transaction:
// insert an entry, or remove the head entry. The output channel (out_valid /
// out_stall) returns exactly one result transaction per command, carrying the
// status, the removed entry and the head entry and count after the command.
// A command is registered when accepted and executed by all cells at once
// as soon as the output register is free or its result is being taken; the
// result is then written to the output register, which raises out_valid.
// A new command is accepted in every cycle while the output is not stalled,
// so throughput is one command per cycle. The rate is set by the cell row:
// value match, insert position and shift all resolve in the same cycle, when
// the command executes.
// While out_stall holds a result, the pending command waits in its register
// and in_stall rises until the result is taken.
// Reset empties the list; entry storage itself is not cleared, and entries
// beyond the current count never reach the outputs.
// ----------------------------------------------------------------------------
module sorted_merge_priority_list_core
    import smpl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      operation,
    input  logic signed [VALUE_W-1:0] item_value,
    input  logic        [KEY_W-1:0]   item_key,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [STATUS_W-1:0]       status,
    output logic signed [VALUE_W-1:0] removed_value,
    output logic        [KEY_W-1:0]   removed_key,
    output logic signed [VALUE_W-1:0] head_value,
    output logic        [KEY_W-1:0]   head_key,
    output logic [COUNT_W-1:0]        entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                      cmd_valid_reg;
    logic                      cmd_valid_next;
    op_t                       cmd_op_reg;
    entry_t                    cmd_reg;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    status_t                   status_reg;
    logic signed [VALUE_W-1:0] removed_value_reg;
    logic        [KEY_W-1:0]   removed_key_reg;
    logic signed [VALUE_W-1:0] head_value_reg;
    logic        [KEY_W-1:0]   head_key_reg;
    logic [COUNT_W-1:0]        entry_count_reg;

    logic                      exec;
    logic                      accept;
    logic                      any_match;
    logic                      full;
    logic                      empty;
    act_t                      act;
    status_t                   status_now;

    cell_tap_t                 taps [CAPACITY];
    entry_t                    nxts [CAPACITY];
    logic                      found [CAPACITY+1];

    assign exec     = cmd_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = cmd_valid_reg && !exec;
    assign accept   = in_valid && !in_stall;

    assign found[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_tap_t left_tap;
        cell_tap_t right_tap;

        if (i == 0)
        begin : g_first
            assign left_tap = '{value: '0, key: '0, ge: 1'b0};
        end
        else
        begin : g_mid
            assign left_tap = taps[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_tap = taps[i];
        end
        else
        begin : g_inner
            assign right_tap = taps[i+1];
        end

        smpl_cell u_cell
        (
            .clk       (clk),
            .act       (act),
            .cmd       (cmd_reg),
            .occupied  (CNT_W'(i) < count_reg),
            .tap_left  (left_tap),
            .tap_right (right_tap),
            .found_in  (found[i]),
            .found_out (found[i+1]),
            .tap       (taps[i]),
            .nxt       (nxts[i])
        );
    end

    assign any_match = found[CAPACITY];
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        act        = ACT_HOLD;
        status_now = ST_INSERTED;
        count_next = count_reg;
        if (cmd_op_reg == OP_INSERT)
        begin
            if (any_match)
            begin
                act        = ACT_MERGE;
                status_now = ST_MERGED;
            end
            else if (full)
            begin
                status_now = ST_FULL;
            end
            else
            begin
                act        = ACT_INSERT;
                status_now = ST_INSERTED;
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            if (empty)
            begin
                status_now = ST_EMPTY;
            end
            else
            begin
                act        = ACT_REMOVE;
                status_now = ST_REMOVED;
                count_next = count_reg - 1'b1;
            end
        end
        if (!exec)
        begin
            act        = ACT_HOLD;
            count_next = count_reg;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (exec)
        begin
            cmd_valid_next = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg;
        end
        if (exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_op_reg <= op_t'(operation);
            cmd_reg    <= '{value: item_value, key: item_key};
        end
        if (exec)
        begin
            status_reg <= status_now;
            if (status_now == ST_REMOVED)
            begin
                removed_value_reg <= taps[0].value;
                removed_key_reg   <= taps[0].key;
            end
            else
            begin
                removed_value_reg <= '0;
                removed_key_reg   <= '0;
            end
            if (count_next == '0)
            begin
                head_value_reg <= '0;
                head_key_reg   <= '0;
            end
            else
            begin
                head_value_reg <= nxts[0].value;
                head_key_reg   <= nxts[0].key;
            end
            entry_count_reg <= COUNT_W'(count_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_value_reg;
    assign removed_key   = removed_key_reg;
    assign head_value    = head_value_reg;
    assign head_key      = head_key_reg;
    assign entry_count   = entry_count_reg;

endmodule

// File: hdl/smpl_checker.sv
// ----------------------------------------------------------------------------
// Sorted merge priority list checker
// Port-level checks on result transactions, bound to the core.
// ----------------------------------------------------------------------------
module smpl_checker
    import smpl_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [STATUS_W-1:0]       status,
    input logic signed [VALUE_W-1:0] removed_value,
    input logic        [KEY_W-1:0]   removed_key,
    input logic signed [VALUE_W-1:0] head_value,
    input logic        [KEY_W-1:0]   head_key,
    input logic [COUNT_W-1:0]        entry_count
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (entry_count == '0) |-> (head_value == '0) && (head_key == '0))
        else $error("head entry not cleared on empty list");

    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_REMOVED) |->
            (removed_value == '0) && (removed_key == '0))
        else $error("removed fields set without a removal");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> (entry_count == '0))
        else $error("empty status with entries held");

endmodule

bind sorted_merge_priority_list_core smpl_checker u_smpl_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .removed_value (removed_value),
    .removed_key   (removed_key),
    .head_value    (head_value),
    .head_key      (head_key),
    .entry_count   (entry_count)
);
